// ===== hdl/ksb_pkg.sv =====
// ----------------------------------------------------------------------------
// ksb_pkg
// Shared types, scancode constants and the set 1 ascii table for the
// keyboard scancode buffer.
// ----------------------------------------------------------------------------
package ksb_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_SCAN   = 2'd0,
    REQ_PEEK   = 2'd1,
    REQ_POP    = 2'd2,
    REQ_STATUS = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_MAKE,
    OP_RELEASE,
    OP_PEEK,
    OP_POP,
    OP_STATUS
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] code;
  } item_t;

  typedef struct packed {
    logic [15:0] key_word;
    logic        key_available;
    logic [7:0]  shift_status;
    logic [7:0]  hold_status;
    logic        key_dropped;
  } result_t;

  localparam logic [7:0] SC_LSHIFT     = 8'h2a;
  localparam logic [7:0] SC_LSHIFT_REL = 8'haa;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hb6;
  localparam logic [7:0] SC_CAPS       = 8'h3a;
  localparam logic [7:0] SC_CAPS_REL   = 8'hba;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_NUM_REL    = 8'hc5;
  localparam logic [7:0] SC_INS        = 8'h52;
  localparam logic [7:0] SC_INS_REL    = 8'hd2;

  // returns {shifted, plain}
  function automatic logic [15:0] ascii_pair(input logic [7:0] code);
    logic [15:0] r;
    case (code)
      8'h02:   r = {8'h21, 8'h31};
      8'h03:   r = {8'h40, 8'h32};
      8'h04:   r = {8'h23, 8'h33};
      8'h05:   r = {8'h24, 8'h34};
      8'h06:   r = {8'h25, 8'h35};
      8'h07:   r = {8'h5e, 8'h36};
      8'h08:   r = {8'h26, 8'h37};
      8'h09:   r = {8'h2a, 8'h38};
      8'h0a:   r = {8'h28, 8'h39};
      8'h0b:   r = {8'h29, 8'h30};
      8'h0c:   r = {8'h5f, 8'h2d};
      8'h0d:   r = {8'h2b, 8'h3d};
      8'h0e:   r = {8'h08, 8'h08};
      8'h0f:   r = {8'h09, 8'h09};
      8'h10:   r = {8'h51, 8'h71};
      8'h11:   r = {8'h57, 8'h77};
      8'h12:   r = {8'h45, 8'h65};
      8'h13:   r = {8'h52, 8'h72};
      8'h14:   r = {8'h54, 8'h74};
      8'h15:   r = {8'h59, 8'h79};
      8'h16:   r = {8'h55, 8'h75};
      8'h17:   r = {8'h49, 8'h69};
      8'h18:   r = {8'h4f, 8'h6f};
      8'h19:   r = {8'h50, 8'h70};
      8'h1a:   r = {8'h7b, 8'h5b};
      8'h1b:   r = {8'h7d, 8'h5d};
      8'h1c:   r = {8'h0d, 8'h0d};
      8'h1e:   r = {8'h41, 8'h61};
      8'h1f:   r = {8'h53, 8'h73};
      8'h20:   r = {8'h44, 8'h64};
      8'h21:   r = {8'h46, 8'h66};
      8'h22:   r = {8'h47, 8'h67};
      8'h23:   r = {8'h48, 8'h68};
      8'h24:   r = {8'h4a, 8'h6a};
      8'h25:   r = {8'h4b, 8'h6b};
      8'h26:   r = {8'h4c, 8'h6c};
      8'h27:   r = {8'h3a, 8'h3b};
      8'h28:   r = {8'h22, 8'h27};
      8'h29:   r = {8'h7e, 8'h60};
      8'h2b:   r = {8'h7c, 8'h5c};
      8'h2c:   r = {8'h5a, 8'h7a};
      8'h2d:   r = {8'h58, 8'h78};
      8'h2e:   r = {8'h43, 8'h63};
      8'h2f:   r = {8'h56, 8'h76};
      8'h30:   r = {8'h42, 8'h62};
      8'h31:   r = {8'h4e, 8'h6e};
      8'h32:   r = {8'h4d, 8'h6d};
      8'h33:   r = {8'h3c, 8'h2c};
      8'h34:   r = {8'h3e, 8'h2e};
      8'h35:   r = {8'h3f, 8'h2f};
      8'h37:   r = {8'h2a, 8'h2a};
      8'h39:   r = {8'h20, 8'h20};
      8'h47:   r = {8'h37, 8'h37};
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ksb_ram.sv =====
// ----------------------------------------------------------------------------
// ksb_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module ksb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ksb_front.sv =====
// ----------------------------------------------------------------------------
// ksb_front
// Accepts request words, classifies them and holds them in a two-word queue
// for the back end.
// ----------------------------------------------------------------------------
module ksb_front import ksb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] scan_byte_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_take_i
);

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;
  item_t      cls;

  always_comb begin
    cls.code = scan_byte_i;
    unique case (req_e'(req_type_i))
      REQ_SCAN:   cls.op = scan_byte_i[7] ? OP_RELEASE : OP_MAKE;
      REQ_PEEK:   cls.op = OP_PEEK;
      REQ_POP:    cls.op = OP_POP;
      REQ_STATUS: cls.op = OP_STATUS;
      default:    cls.op = OP_STATUS;
    endcase
  end

  assign full_o       = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== hdl/ksb_back.sv =====
// ----------------------------------------------------------------------------
// ksb_back
// Carries out classified requests: status bit updates, ascii translation,
// keystroke ring push, peek and pop, and holds the result word.
// ----------------------------------------------------------------------------
module ksb_back import ksb_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_take_o,
  input  logic    result_take_i,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

  localparam int unsigned SH_RSHIFT = 0;
  localparam int unsigned SH_LSHIFT = 1;
  localparam int unsigned SH_NUM    = 5;
  localparam int unsigned SH_CAPS   = 6;
  localparam int unsigned HD_NUM    = 5;
  localparam int unsigned HD_CAPS   = 6;
  localparam int unsigned HD_INS    = 7;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  state_e        state_q, state_d;
  logic [7:0]    shift_q, shift_d;
  logic [7:0]    held_q, held_d;
  logic [AW-1:0] rd_slot_q, rd_slot_d;
  logic [AW-1:0] wr_slot_q, wr_slot_d;
  logic          is_pop_q, is_pop_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;
  logic          out_load;
  logic          out_free;

  logic [7:0]    upd_shift;
  logic [7:0]    upd_held;
  logic          shifted;
  logic [15:0]   pair;
  logic [7:0]    ascii;

  logic          ram_we;
  logic          ram_re;
  logic [15:0]   ram_rdata;

  // status update for a scancode byte
  always_comb begin
    upd_shift = shift_q;
    upd_held  = held_q;
    case (item_i.code)
      SC_LSHIFT:     upd_shift[SH_LSHIFT] = 1'b1;
      SC_LSHIFT_REL: upd_shift[SH_LSHIFT] = 1'b0;
      SC_RSHIFT:     upd_shift[SH_RSHIFT] = 1'b1;
      SC_RSHIFT_REL: upd_shift[SH_RSHIFT] = 1'b0;
      SC_CAPS: begin
        upd_shift[SH_CAPS] = !shift_q[SH_CAPS];
        upd_held[HD_CAPS]  = 1'b1;
      end
      SC_CAPS_REL:   upd_held[HD_CAPS] = 1'b0;
      SC_NUM: begin
        upd_shift[SH_NUM] = !shift_q[SH_NUM];
        upd_held[HD_NUM]  = 1'b1;
      end
      SC_NUM_REL:    upd_held[HD_NUM] = 1'b0;
      SC_INS:        upd_held[HD_INS] = 1'b1;
      SC_INS_REL:    upd_held[HD_INS] = 1'b0;
      default:       ;
    endcase
  end

  assign shifted  = (upd_shift[SH_RSHIFT] || upd_shift[SH_LSHIFT]) ^ upd_shift[SH_CAPS];
  assign pair     = ascii_pair(item_i.code);
  assign ascii    = shifted ? pair[15:8] : pair[7:0];
  assign out_free = !out_valid_q || result_take_i;

  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    held_d      = held_q;
    rd_slot_d   = rd_slot_q;
    wr_slot_d   = wr_slot_q;
    is_pop_d    = is_pop_q;
    item_take_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_load    = 1'b0;
    out_d       = '{key_word: 16'h0000, key_available: 1'b0,
                    shift_status: shift_q, hold_status: held_q, key_dropped: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i && out_free) begin
          item_take_o = 1'b1;
          unique case (item_i.op) inside
            OP_MAKE, OP_RELEASE: begin
              shift_d            = upd_shift;
              held_d             = upd_held;
              out_load           = 1'b1;
              out_d.shift_status = upd_shift;
              out_d.hold_status  = upd_held;
              if (item_i.op == OP_MAKE) begin
                if (next_slot(wr_slot_q) == rd_slot_q) begin
                  out_d.key_dropped = 1'b1;
                end else begin
                  ram_we    = 1'b1;
                  wr_slot_d = next_slot(wr_slot_q);
                end
              end
            end
            OP_PEEK, OP_POP: begin
              if (rd_slot_q == wr_slot_q) begin
                out_load = 1'b1;
              end else begin
                ram_re   = 1'b1;
                is_pop_d = (item_i.op == OP_POP);
                state_d  = ST_READ;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_load            = 1'b1;
        out_d.key_word      = ram_rdata;
        out_d.key_available = 1'b1;
        if (is_pop_q) begin
          rd_slot_d = next_slot(rd_slot_q);
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load ? 1'b1 : (result_take_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= 8'h00;
      held_q      <= 8'h00;
      rd_slot_q   <= '0;
      wr_slot_q   <= '0;
      is_pop_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shift_q     <= shift_d;
      held_q      <= held_d;
      rd_slot_q   <= rd_slot_d;
      wr_slot_q   <= wr_slot_d;
      is_pop_q    <= is_pop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  ksb_ram #(
    .WIDTH (16),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_slot_q),
    .wdata_i ({item_i.code, ascii}),
    .re_i    (ram_re),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

// ===== hdl/keyboard_scancode_buffer.sv =====
// ----------------------------------------------------------------------------
// keyboard_scancode_buffer
// Scancode set 1 keyboard buffer with shift status and a keystroke ring.
// ----------------------------------------------------------------------------
// Requests enter through a two-word queue and each gives exactly one result
// word, in order. Scancode bytes, status reads and a peek or pop on an empty
// ring finish in the back end as they are taken, so they run at one word per
// clock while the result is popped every clock; a peek or pop that finds a key
// also passes a read state, set by the registered read port of the keystroke
// ring memory, and no new request is taken before its key is loaded. A request
// passes the queue entry register, then the result register, on its way out.
// The ring holds RING_DEPTH - 1 keystrokes; a make code that finds it full is
// dropped and flagged. Ring entries need no clearing after reset.
module keyboard_scancode_buffer import ksb_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  scan_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] key_word_o,
  output logic        key_available_o,
  output logic [7:0]  shift_status_o,
  output logic [7:0]  hold_status_o,
  output logic        key_dropped_o
);

  logic    item_valid;
  item_t   item;
  logic    item_take;
  logic    result_valid;
  result_t result;

  ksb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .req_type_i   (req_type_i),
    .scan_byte_i  (scan_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  ksb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_take_o    (item_take),
    .result_take_i  (pop && result_valid),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  assign empty           = !result_valid;
  assign key_word_o      = result.key_word;
  assign key_available_o = result.key_available;
  assign shift_status_o  = result.shift_status;
  assign hold_status_o   = result.hold_status;
  assign key_dropped_o   = result.key_dropped;

endmodule

// ===== hdl/ksb_checker.sv =====
// ----------------------------------------------------------------------------
// ksb_checker
// Port level assertions for the keyboard scancode buffer, bound to the top.
// ----------------------------------------------------------------------------
module ksb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [15:0] key_word_o,
  input logic        key_available_o,
  input logic [7:0]  shift_status_o,
  input logic [7:0]  hold_status_o,
  input logic        key_dropped_o
);

  // no result word while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // a waiting result word holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(key_word_o) && $stable(key_available_o)
                          && $stable(shift_status_o) && $stable(hold_status_o)
                          && $stable(key_dropped_o)))
    else $error("result word changed before pop");

  // no key word without a key, and a drop never comes with a key
  a_word_needs_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !key_available_o) |-> (key_word_o == 16'h0000))
    else $error("key word without key");

  a_drop_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && key_dropped_o) |-> !key_available_o)
    else $error("dropped flag with key");

  // unused status bits stay clear
  a_status_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((shift_status_o[7] == 1'b0) && (shift_status_o[4:2] == 3'b000)
                && (hold_status_o[4:0] == 5'b00000)))
    else $error("undefined status bit set");

endmodule

bind keyboard_scancode_buffer ksb_checker u_ksb_checker (.*);
